[src/rgb_channel_histogram_unit_macros.svh]
// assertion macros of the histogram unit
// no dependencies; included by the top level only
`ifndef RGB_CHANNEL_HISTOGRAM_UNIT_MACROS_SVH
`define RGB_CHANNEL_HISTOGRAM_UNIT_MACROS_SVH

// same-cycle implication
`define RCH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rch_pkg.sv]
// shared constants, types and helpers of the rgb channel histogram unit
// no dependencies; imported by every module of the block
package rch_pkg;

    localparam int COUNT_BITS     = 32;
    localparam int MAX_ROW_PIXELS = 4096;
    localparam int BIN_COUNT      = 16;
    localparam int CHANNELS       = 3;

    localparam int BIN_W     = $clog2(BIN_COUNT);
    localparam int CH_W      = 2;
    localparam int ADDR_W    = CH_W + BIN_W;
    localparam int MEM_DEPTH = CHANNELS * BIN_COUNT;

    localparam int WIDTH_W  = 13;
    localparam int POS_W    = 14;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // request codes on the input channel
    localparam logic [1:0] REQ_PIXEL = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [CH_W-1:0] CH_NONE   = 2'd3;
    localparam logic [4:0]      SEL_TOTAL = 5'd16;

    // register index decoded from paddr
    localparam logic REG_ROW_PIXELS = 1'b0;

    // operation codes between front and back
    localparam logic [2:0] OP_COUNT      = 3'd0;
    localparam logic [2:0] OP_READ_BIN   = 3'd1;
    localparam logic [2:0] OP_READ_TOTAL = 3'd2;
    localparam logic [2:0] OP_READ_ZERO  = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;

    typedef struct packed {
        logic [2:0]       op;
        logic [CH_W-1:0]  ch;
        logic [BIN_W-1:0] bin;
    } rch_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rch_q_status_t;

    typedef struct packed {
        logic read_fire;
        logic blocked;
    } rch_back_status_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        sat_inc = (&v) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

[src/rch_front.sv]
// front part: config register, row position tracking and request classification
// depends on rch_pkg; feeds rch_queue
module rch_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rch_pkg::PADDR_W-1:0]   paddr,
    input  logic [rch_pkg::PDATA_W-1:0]   pwdata,
    output logic [rch_pkg::PDATA_W-1:0]   prdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    req_type,
    input  logic [7:0]                    data_byte,
    input  logic [1:0]                    channel_sel,
    input  logic [4:0]                    bin_sel,
    input  rch_pkg::rch_q_status_t        q_st,
    output logic                          push,
    output rch_pkg::rch_item_t            item
);
    import rch_pkg::*;

    logic [WIDTH_W-1:0] row_pixels_reg;
    logic [POS_W-1:0]   data_len_reg, data_len_next;
    logic [POS_W-1:0]   row_len_reg, row_len_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         phase_reg, phase_next;

    logic               cfg_wr;
    logic [WIDTH_W-1:0] w_raw, w_eff;
    logic [POS_W-1:0]   w_ext, len_sum;
    logic               accept, want_push, counted, wrap;
    logic [POS_W:0]     pos_inc;

    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ROW_PIXELS);
    assign prdata = (paddr[PADDR_W-1] == REG_ROW_PIXELS) ?
                    PDATA_W'(row_pixels_reg) : '0;

    // clamp the width, then data bytes and padded row length
    always_comb
    begin
        w_raw = pwdata[WIDTH_W-1:0];
        if (w_raw == '0)
            w_eff = WIDTH_W'(1);
        else if (w_raw > WIDTH_W'(MAX_ROW_PIXELS))
            w_eff = WIDTH_W'(MAX_ROW_PIXELS);
        else
            w_eff = w_raw;
        w_ext         = POS_W'(w_eff);
        data_len_next = (w_ext << 1) + w_ext;
        len_sum       = data_len_next + POS_W'(3);
        row_len_next  = {len_sum[POS_W-1:2], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pixels_reg <= WIDTH_W'(1);
            data_len_reg   <= POS_W'(3);
            row_len_reg    <= POS_W'(4);
        end
        else if (cfg_wr)
        begin
            row_pixels_reg <= w_raw;
            data_len_reg   <= data_len_next;
            row_len_reg    <= row_len_next;
        end
    end

    assign in_stall = q_st.full;
    assign accept   = in_valid && !in_stall;

    assign counted = (pos_reg < data_len_reg);
    assign pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign wrap    = (pos_inc >= {1'b0, row_len_reg});

    always_comb
    begin
        want_push  = 1'b0;
        item.op    = OP_COUNT;
        item.ch    = '0;
        item.bin   = '0;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        case (req_type)
            REQ_PIXEL:
            begin
                want_push = counted;
                item.op   = OP_COUNT;
                item.ch   = phase_reg;
                item.bin  = data_byte[7:4];
                if (accept)
                begin
                    pos_next   = wrap ? '0 : pos_inc[POS_W-1:0];
                    phase_next = (wrap || phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                end
            end
            REQ_READ:
            begin
                want_push = 1'b1;
                if (channel_sel == CH_NONE || bin_sel > SEL_TOTAL)
                    item.op = OP_READ_ZERO;
                else if (bin_sel inside {[5'd0:5'd15]})
                begin
                    item.op  = OP_READ_BIN;
                    item.ch  = channel_sel;
                    item.bin = bin_sel[BIN_W-1:0];
                end
                else
                begin
                    item.op = OP_READ_TOTAL;
                    item.ch = channel_sel;
                end
            end
            REQ_CLEAR:
            begin
                want_push = 1'b1;
                item.op   = OP_CLEAR;
                if (accept)
                begin
                    pos_next   = '0;
                    phase_next = 2'd0;
                end
            end
            default:
            begin
                want_push = 1'b0;
            end
        endcase
    end

    assign push = accept && want_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= 2'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

endmodule

[src/rch_queue.sv]
// short fifo of classified operations between front and back
// depends on rch_pkg
module rch_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rch_pkg::rch_item_t     push_item,
    input  logic                   pop,
    output rch_pkg::rch_item_t     head,
    output rch_pkg::rch_q_status_t q_st
);
    import rch_pkg::*;

    rch_item_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign q_st.full  = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign q_st.empty = (cnt_reg == '0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + Q_CNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - Q_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            cnt_reg <= cnt_next;
        end
    end

endmodule

[src/rch_back.sv]
// back part: bin memory with read-modify-write, channel totals, output register
// depends on rch_pkg; pulls operations from rch_queue
module rch_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rch_pkg::rch_item_t                head,
    input  rch_pkg::rch_q_status_t            q_st,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rch_pkg::COUNT_BITS-1:0]    count_value,
    output rch_pkg::rch_back_status_t         back_st
);
    import rch_pkg::*;

    logic [COUNT_BITS-1:0] bin_mem [MEM_DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [MEM_DEPTH-1:0]  bin_ok_reg;
    logic [COUNT_BITS-1:0] total_reg [CHANNELS];

    logic                  b_valid_reg;
    rch_item_t             b_item_reg;

    logic                  fwd_valid_reg;
    logic [ADDR_W-1:0]     fwd_addr_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] count_reg;

    logic [ADDR_W-1:0]     head_addr, b_addr;
    logic                  b_read, b_count, b_clear, adv;
    logic [COUNT_BITS-1:0] bin_val, bin_inc, read_val;

    assign head_addr = {head.ch, head.bin};
    assign b_addr    = {b_item_reg.ch, b_item_reg.bin};

    assign b_read  = b_valid_reg && (b_item_reg.op == OP_READ_BIN ||
                     b_item_reg.op == OP_READ_TOTAL || b_item_reg.op == OP_READ_ZERO);
    assign b_count = b_valid_reg && (b_item_reg.op == OP_COUNT);
    assign b_clear = b_valid_reg && (b_item_reg.op == OP_CLEAR);

    // only a read facing a held result has to wait
    assign adv = !(b_read && out_valid_reg && out_stall);
    assign pop = adv && !q_st.empty;

    // the write at the edge that loaded this stage is not in rd_data_reg
    always_comb
    begin
        if (fwd_valid_reg && fwd_addr_reg == b_addr)
            bin_val = fwd_data_reg;
        else if (bin_ok_reg[b_addr])
            bin_val = rd_data_reg;
        else
            bin_val = '0;
        bin_inc = sat_inc(bin_val);
    end

    always_comb
    begin
        case (b_item_reg.op)
            OP_READ_BIN:   read_val = bin_val;
            OP_READ_TOTAL: read_val = total_reg[b_item_reg.ch];
            default:       read_val = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= bin_mem[head_addr];
        if (b_count)
            bin_mem[b_addr] <= bin_inc;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            b_item_reg <= head;
        if (b_count)
        begin
            fwd_addr_reg <= b_addr;
            fwd_data_reg <= bin_inc;
        end
        if (b_read && adv)
            count_reg <= read_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            bin_ok_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
                total_reg[c] <= '0;
        end
        else
        begin
            if (adv)
                b_valid_reg <= pop;
            if (b_clear)
            begin
                fwd_valid_reg <= 1'b0;
                bin_ok_reg    <= '0;
                for (int c = 0; c < CHANNELS; c++)
                    total_reg[c] <= '0;
            end
            else if (b_count)
            begin
                fwd_valid_reg      <= 1'b1;
                bin_ok_reg[b_addr] <= 1'b1;
                for (int c = 0; c < CHANNELS; c++)
                    if (b_item_reg.ch == CH_W'(c))
                        total_reg[c] <= sat_inc(total_reg[c]);
            end
            if (b_read && adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign count_value       = count_reg;
    assign back_st.read_fire = b_read && adv;
    assign back_st.blocked   = !adv;

endmodule

[src/rgb_channel_histogram_unit.sv]
// Per-channel 16-bin histogram of a 24-bit pixel array, fed one byte per transaction.
// Input channel (in_valid/in_stall): req_type selects pixel byte, counter read or clear.
// Pixel bytes are counted in blue, green, red order; row padding to 4 bytes is skipped
// using row_pixels (APB, byte address 0, resets to 1, kept raw, used as 1..4096).
// Output channel (out_valid/out_stall): one count_value transaction per read request,
// bins and totals saturate at all ones. Other requests give no output.
// Throughput: one input transaction per cycle while in_stall is low; bin memory is read
// ahead of its write, the last write forwarded: a byte retires each unblocked cycle.
// A read passes the queue, the back stage and the output register before its result is
// valid; requests are applied strictly in order.
// A four-entry queue sits between the classifying front and the counting back; while
// the output is stalled, bytes and clears keep flowing until a read reaches the back,
// then that read waits, the queue fills and in_stall rises.
// Reset clears all counters and the row position at once and sets row_pixels to 1.
// Depends on rch_pkg, rch_front, rch_queue, rch_back and the assertion macro header.
module rgb_channel_histogram_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rch_pkg::PADDR_W-1:0]       paddr,
    input  logic [rch_pkg::PDATA_W-1:0]       pwdata,
    output logic [rch_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        req_type,
    input  logic [7:0]                        data_byte,
    input  logic [1:0]                        channel_sel,
    input  logic [4:0]                        bin_sel,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rch_pkg::COUNT_BITS-1:0]    count_value
);
    import rch_pkg::*;

    `include "rgb_channel_histogram_unit_macros.svh"

    rch_item_t         push_item, head;
    rch_q_status_t     q_st;
    rch_back_status_t  back_st;
    logic              push, pop;
    logic              read_fire, blocked, out_held;

    assign pready = 1'b1;

    rch_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .channel_sel (channel_sel),
        .bin_sel     (bin_sel),
        .q_st        (q_st),
        .push        (push),
        .item        (push_item)
    );

    rch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .q_st      (q_st)
    );

    rch_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_st        (q_st),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .count_value (count_value),
        .back_st     (back_st)
    );

    assign read_fire = back_st.read_fire;
    assign blocked   = back_st.blocked;
    assign out_held  = out_valid && out_stall;

    `RCH_ASSERT_IMPL(a_no_queue_overflow, clk, rst_n, push, !q_st.full, "push into full queue")
    `RCH_ASSERT_NEXT(a_read_sets_output, clk, rst_n, read_fire, out_valid, "read result lost")
    `RCH_ASSERT_IMPL(a_no_overwrite, clk, rst_n, read_fire, !out_held, "held result overwritten")
    `RCH_ASSERT_IMPL(a_blocked_held, clk, rst_n, blocked, out_held, "stall without result")

endmodule
